// File: src/assert_macros.svh
// Assertion macros shared by the flood limiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define PCFL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PCFL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/pcfl_pkg.sv
// Types, constants and codes shared by the flood limiter files.
package pcfl_pkg;

   localparam int DEF_CHANNELS = 64;
   localparam int CHAN_W       = 6;
   localparam int TIME_W       = 32;
   localparam int COUNT_W      = 16;
   localparam int CFG_W        = 16;
   localparam int CSR_IDX_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FLOOD_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SECONDS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE_SECONDS  = 2'd2;

   localparam logic [CFG_W-1:0] RST_FLOOD_THRESHOLD = 16'd0;
   localparam logic [CFG_W-1:0] RST_WINDOW_SECONDS  = 16'd5;
   localparam logic [CFG_W-1:0] RST_IGNORE_SECONDS  = 16'd60;

   localparam logic MODE_CHECK = 1'b0;
   localparam logic MODE_SWEEP = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SWEEP
   } pcfl_state_type;

   typedef struct packed {
      logic               valid;
      logic [TIME_W-1:0]  window_start;
      logic [COUNT_W-1:0] message_count;
      logic [TIME_W-1:0]  ignore_since;
   } pcfl_entry_type;

   typedef struct packed {
      logic write_entry;
      logic drop;
      logic ignore_started;
   } pcfl_update_type;

endpackage

// File: src/pcfl_req_if.sv
// Request channel: one check or sweep item per handshake.
interface pcfl_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [pcfl_pkg::CHAN_W-1:0]   channel;
   logic [pcfl_pkg::TIME_W-1:0]   current_time;

   modport source (output valid, mode, channel, current_time, input ready);
   modport sink   (input valid, mode, channel, current_time, output ready);
endinterface

// File: src/pcfl_rsp_if.sv
// Response channel: one verdict item per request item.
interface pcfl_rsp_if;
   logic valid;
   logic ready;
   logic drop;
   logic ignore_started;

   modport source (output valid, drop, ignore_started, input ready);
   modport sink   (input valid, drop, ignore_started, output ready);
endinterface

// File: src/per_channel_flood_limiter_unit.sv
// Top level of the per-channel flood limiter with its record table and control.
//
// Usage. Request items arrive on req_chan: mode 0 checks one message on the
// given channel at current_time, mode 1 sweeps the whole table and lifts every
// ignore that has run out. Each request item gives exactly one response item
// on rsp_chan, carrying drop and ignore_started, in request order.
// Timing. The record of a check is read at the edge that accepts the item. In
// the check state it is updated, and it is written back as the response is
// loaded, which waits while the output register holds an item not yet taken.
// A new request item is accepted only once the one before it has loaded its
// response. A sweep walks all CHANNELS records through the one read port and
// the one write port of the table.
// Reset. After reset the table is cleared one record per cycle; no request item
// is accepted during that time, while the csr_ registers may be written at any
// time. The registers reset to a threshold of 0 (limiting off), a window of 5 s
// and an ignore of 60 s.
// Stalls. The response sits in an output register. A new request item may be
// accepted while it waits; the next result is held back, with its table write,
// until the waiting item has been taken.
module per_channel_flood_limiter_unit #(
   parameter int CHANNELS = pcfl_pkg::DEF_CHANNELS
) (
   input  logic                              clock,
   input  logic                              reset,
   pcfl_req_if.sink                          req_chan,
   pcfl_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [pcfl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pcfl_pkg::CFG_W-1:0]        csr_wr_data
);

   `include "assert_macros.svh"

   // Table address width, and a counter wide enough to hold CHANNELS itself.
   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CW = $clog2(CHANNELS + 1);
   localparam int EW = $bits(pcfl_pkg::pcfl_entry_type);

   // Configuration registers.
   logic [pcfl_pkg::CFG_W-1:0]  thr_ff, wsec_ff, isec_ff;

   // Control state.
   pcfl_pkg::pcfl_state_type    state_ff, state_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic                        wr_vld_ff, wr_vld_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // Item and result payload.
   logic [AW-1:0]               wr_addr_ff, wr_addr_in;
   logic                        mode_ff, mode_in;
   logic                        bypass_ff, bypass_in;
   logic [AW-1:0]               addr_ff, addr_in;
   logic [pcfl_pkg::TIME_W-1:0] now_ff, now_in;
   logic                        drop_ff, drop_in;
   logic                        started_ff, started_in;

   // Table port signals.
   logic                        ram_wr_en;
   logic [AW-1:0]               ram_wr_addr;
   pcfl_pkg::pcfl_entry_type    ram_wr_data;
   logic                        ram_rd_en;
   logic [AW-1:0]               ram_rd_addr;
   logic [EW-1:0]               ram_rd_data;

   pcfl_pkg::pcfl_entry_type    upd_entry;
   pcfl_pkg::pcfl_update_type   upd;

   logic [15:0]                 ch_wide;
   logic                        ch_in_range;
   logic                        out_free;
   logic                        req_ready;

   assign ch_wide     = 16'(req_chan.channel);
   assign ch_in_range = 32'(req_chan.channel) < CHANNELS;
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;

   // One record per channel: valid flag, window start, count and ignore time.
   pcfl_ram #(
      .WIDTH (EW),
      .DEPTH (CHANNELS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pcfl_update u_update (
      .mode       (mode_ff),
      .entry_in   (pcfl_pkg::pcfl_entry_type'(ram_rd_data)),
      .now        (now_ff),
      .threshold  (thr_ff),
      .window_sec (wsec_ff),
      .ignore_sec (isec_ff),
      .entry_out  (upd_entry),
      .update     (upd)
   );

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= pcfl_pkg::RST_FLOOD_THRESHOLD;
         wsec_ff <= pcfl_pkg::RST_WINDOW_SECONDS;
         isec_ff <= pcfl_pkg::RST_IGNORE_SECONDS;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            pcfl_pkg::CSR_FLOOD_THRESHOLD: thr_ff  <= csr_wr_data;
            pcfl_pkg::CSR_WINDOW_SECONDS:  wsec_ff <= csr_wr_data;
            pcfl_pkg::CSR_IGNORE_SECONDS:  isec_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcfl_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         wr_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wr_vld_ff    <= wr_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      mode_ff    <= mode_in;
      bypass_ff  <= bypass_in;
      addr_ff    <= addr_in;
      now_ff     <= now_in;
      drop_ff    <= drop_in;
      started_ff <= started_in;
   end

   // Sequencer. The clear pass zeroes every record after reset. A check reads
   // its record, then updates and writes it back as the result is loaded. A
   // sweep streams reads through the table and writes each lifted record back in
   // the cycle after its read, so read and write never meet on one record.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      wr_vld_in    = 1'b0;
      wr_addr_in   = wr_addr_ff;
      mode_in      = mode_ff;
      bypass_in    = bypass_ff;
      addr_in      = addr_ff;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      drop_in      = drop_ff;
      started_in   = started_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_addr_ff;
      ram_wr_data  = upd_entry;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ch_wide[AW-1:0];
      req_ready    = 1'b0;
      unique case (state_ff)
         pcfl_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff[AW-1:0];
            ram_wr_data = '0;
            if (cnt_ff == CW'(CHANNELS - 1)) begin
               state_in = pcfl_pkg::ST_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         pcfl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               mode_in   = req_chan.mode;
               now_in    = req_chan.current_time;
               addr_in   = ch_wide[AW-1:0];
               // Limiting off or an unknown channel: pass, leave the table alone.
               bypass_in = (thr_ff == '0) || !ch_in_range;
               if (req_chan.mode == pcfl_pkg::MODE_SWEEP) begin
                  state_in = pcfl_pkg::ST_SWEEP;
                  cnt_in   = '0;
               end else begin
                  ram_rd_en = 1'b1;
                  state_in  = pcfl_pkg::ST_CHECK;
               end
            end
         end
         pcfl_pkg::ST_CHECK: begin
            ram_wr_addr = addr_ff;
            if (out_free) begin
               ram_wr_en    = !bypass_ff;
               rsp_valid_in = 1'b1;
               drop_in      = !bypass_ff && upd.drop;
               started_in   = !bypass_ff && upd.ignore_started;
               state_in     = pcfl_pkg::ST_IDLE;
            end
         end
         pcfl_pkg::ST_SWEEP: begin
            ram_wr_en = wr_vld_ff && upd.write_entry;
            if (cnt_ff != CW'(CHANNELS)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cnt_ff[AW-1:0];
               cnt_in      = cnt_ff + CW'(1);
               wr_vld_in   = 1'b1;
               wr_addr_in  = cnt_ff[AW-1:0];
            end else if (!wr_vld_ff && out_free) begin
               rsp_valid_in = 1'b1;
               drop_in      = 1'b0;
               started_in   = 1'b0;
               state_in     = pcfl_pkg::ST_IDLE;
            end
         end
      endcase
   end

   assign req_chan.ready          = req_ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.drop           = drop_ff;
   assign rsp_chan.ignore_started = started_ff;

   `PCFL_ASSERT(a_check_goes_to_update, clock, reset, (req_chan.valid && req_chan.ready && req_chan.mode == pcfl_pkg::MODE_CHECK) |=> (state_ff == pcfl_pkg::ST_CHECK), "accepted check item did not move on to its update cycle")
   `PCFL_ASSERT(a_bypass_no_write, clock, reset, (state_ff == pcfl_pkg::ST_CHECK && bypass_ff) |-> !ram_wr_en, "bypassed check item wrote the table")
   `PCFL_ASSERT(a_start_means_drop, clock, reset, (rsp_valid_ff && started_ff) |-> drop_ff, "ignore started without dropping the item")
   `PCFL_ASSERT(a_sweep_count_bound, clock, reset, cnt_ff <= CW'(CHANNELS), "table walk counter ran past the last channel")

endmodule

// File: src/pcfl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pcfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/pcfl_update.sv
// Entry update for one check or one sweep step on a record read from the table.
module pcfl_update (
   input  logic                             mode,
   input  pcfl_pkg::pcfl_entry_type         entry_in,
   input  logic [pcfl_pkg::TIME_W-1:0]      now,
   input  logic [pcfl_pkg::CFG_W-1:0]       threshold,
   input  logic [pcfl_pkg::CFG_W-1:0]       window_sec,
   input  logic [pcfl_pkg::CFG_W-1:0]       ignore_sec,
   output pcfl_pkg::pcfl_entry_type         entry_out,
   output pcfl_pkg::pcfl_update_type        update
);

   pcfl_pkg::pcfl_entry_type          base;
   logic [pcfl_pkg::TIME_W:0]         win_end;
   logic [pcfl_pkg::TIME_W:0]         ign_end;
   logic                              expired;
   logic                              lift;
   logic [pcfl_pkg::COUNT_W-1:0]      count_inc;

   // A record seen for the first time starts its window now.
   always_comb begin
      if (entry_in.valid) begin
         base = entry_in;
      end else begin
         base.valid         = 1'b1;
         base.window_start  = now;
         base.message_count = '0;
         base.ignore_since  = '0;
      end
   end

   // Both limits are compared as start + length < now, which cannot wrap.
   assign win_end   = {1'b0, base.window_start} + (pcfl_pkg::TIME_W + 1)'(window_sec);
   assign ign_end   = {1'b0, entry_in.ignore_since} + (pcfl_pkg::TIME_W + 1)'(ignore_sec);
   assign expired   = win_end < {1'b0, now};
   assign lift      = entry_in.valid && (entry_in.ignore_since != '0) &&
                      (ign_end < {1'b0, now});
   assign count_inc = base.message_count + pcfl_pkg::COUNT_W'(1);

   always_comb begin
      entry_out             = base;
      update.write_entry    = 1'b0;
      update.drop           = 1'b0;
      update.ignore_started = 1'b0;
      if (mode == pcfl_pkg::MODE_SWEEP) begin
         entry_out              = entry_in;
         entry_out.ignore_since = '0;
         update.write_entry     = lift;
      end else begin
         update.write_entry = 1'b1;
         priority if (base.ignore_since != '0) begin
            update.drop = 1'b1;
         end else if (expired) begin
            entry_out.window_start  = now;
            entry_out.message_count = '0;
         end else if (count_inc >= threshold) begin
            entry_out.message_count = '0;
            entry_out.window_start  = '0;
            entry_out.ignore_since  = now;
            update.drop             = 1'b1;
            update.ignore_started   = 1'b1;
         end else begin
            entry_out.message_count = count_inc;
         end
      end
   end

endmodule

// File: bench/per_channel_flood_limiter_unit_test.sv
// Self-checking testbench for the per-channel flood limiter, with its own scoreboard model.
module per_channel_flood_limiter_unit_test;

   localparam int CHANNELS = pcfl_pkg::DEF_CHANNELS;

   // The longest stretch with no handshake on either side that a correct run can show.
   // A sweep and the clearing pass after reset each walk all CHANNELS records of the
   // table, and the limit is set many times longer than such a walk.
   localparam int QUIET_LIMIT = 40 * (CHANNELS + 4);

   // Chance, in percent, that a side idles in a given cycle.
   localparam int IDLE_PERCENT = 37;

   // Expected verdict of one request item.
   typedef struct packed {
      logic drop;
      logic ignore_started;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           csr_wr_en;
   logic [pcfl_pkg::CSR_IDX_W-1:0] csr_index;
   logic [pcfl_pkg::CFG_W-1:0]     csr_wr_data;

   pcfl_req_if req_chan ();
   pcfl_rsp_if rsp_chan ();

   per_channel_flood_limiter_unit #(
      .CHANNELS (CHANNELS)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the register file, kept in step with every write.
   logic [pcfl_pkg::CFG_W-1:0] threshold_setting;
   logic [pcfl_pkg::CFG_W-1:0] window_setting;
   logic [pcfl_pkg::CFG_W-1:0] ignore_setting;

   // Shadow copy of the record table.
   logic                         chan_known        [CHANNELS];
   logic [pcfl_pkg::TIME_W-1:0]  chan_window_start [CHANNELS];
   logic [pcfl_pkg::COUNT_W-1:0] chan_count        [CHANNELS];
   logic [pcfl_pkg::TIME_W-1:0]  chan_ignored_at   [CHANNELS];

   // Verdicts owed by the block, oldest first.
   verdict_type pending_verdicts [$];

   int  mismatch_count = 0;
   int  quiet_cycles   = 0;

   // When set, neither side idles; this gives the block a long stretch of back-to-back
   // traffic at its full rate.
   bit  steady_traffic = 1'b0;

   // Works out the verdict of a check item and updates the shadow table as the block
   // should. All time comparisons are done at 64 bits so that nothing wraps.
   function automatic verdict_type judge_message(input logic [pcfl_pkg::CHAN_W-1:0] ch,
                                                 input logic [pcfl_pkg::TIME_W-1:0] now);
      verdict_type verdict;
      longint      now_wide;
      longint      start_wide;
      longint      span_wide;
      verdict = '0;
      // A threshold of zero switches limiting off altogether: nothing is recorded.
      if (threshold_setting == '0) begin
         return verdict;
      end
      // A channel seen for the first time opens its window now.
      if (!chan_known[ch]) begin
         chan_known[ch]        = 1'b1;
         chan_window_start[ch] = now;
         chan_count[ch]        = '0;
         chan_ignored_at[ch]   = '0;
      end
      // A channel under an ignore drops everything and keeps its record as it is.
      if (chan_ignored_at[ch] != '0) begin
         verdict.drop = 1'b1;
         return verdict;
      end
      now_wide   = longint'(now);
      start_wide = longint'(chan_window_start[ch]);
      span_wide  = longint'(window_setting);
      // Once the window has run out, a new one starts and the message passes uncounted.
      if (start_wide < now_wide - span_wide) begin
         chan_window_start[ch] = now;
         chan_count[ch]        = '0;
         return verdict;
      end
      chan_count[ch] = chan_count[ch] + pcfl_pkg::COUNT_W'(1);
      // Reaching the threshold starts the ignore. An ignore started at time zero leaves
      // the stamp at zero, so the channel does not count as ignored afterwards.
      if (chan_count[ch] >= threshold_setting) begin
         chan_count[ch]         = '0;
         chan_window_start[ch]  = '0;
         chan_ignored_at[ch]    = now;
         verdict.drop           = 1'b1;
         verdict.ignore_started = 1'b1;
      end
      return verdict;
   endfunction

   // Lifts every ignore that is older than the ignore period; a sweep always passes.
   function automatic verdict_type lift_expired_ignores(input logic [pcfl_pkg::TIME_W-1:0] now);
      longint now_wide;
      longint span_wide;
      longint stamp_wide;
      now_wide  = longint'(now);
      span_wide = longint'(ignore_setting);
      for (int c = 0; c < CHANNELS; c++) begin
         stamp_wide = longint'(chan_ignored_at[c]);
         if (chan_known[c] && chan_ignored_at[c] != '0 && stamp_wide < now_wide - span_wide) begin
            chan_ignored_at[c] = '0;
         end
      end
      return '0;
   endfunction

   // Offers one item on the request channel, idling first at random, and files the
   // expected verdict once the block has taken it. The valid line is left high on
   // return, so that a following item can go out in the very next cycle.
   task automatic issue_request(input logic mode_bit,
                                input logic [pcfl_pkg::CHAN_W-1:0] ch,
                                input logic [pcfl_pkg::TIME_W-1:0] now);
      while (!steady_traffic && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.mode         <= mode_bit;
      req_chan.channel      <= ch;
      req_chan.current_time <= now;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) begin
         @(posedge clock);
      end
      if (mode_bit == pcfl_pkg::MODE_SWEEP) begin
         pending_verdicts.push_back(lift_expired_ignores(now));
      end else begin
         pending_verdicts.push_back(judge_message(ch, now));
      end
   endtask

   // Stops offering items and waits until every verdict is in, then waits out longer
   // than a walk over all CHANNELS records before the block is taken to be idle.
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      while (pending_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (CHANNELS + 4) @(posedge clock);
   endtask

   // Writes one register and mirrors the value into the shadow copy.
   task automatic write_register(input logic [pcfl_pkg::CSR_IDX_W-1:0] index,
                                 input logic [pcfl_pkg::CFG_W-1:0] value);
      case (index)
         pcfl_pkg::CSR_FLOOD_THRESHOLD: begin
            threshold_setting = value;
         end
         pcfl_pkg::CSR_WINDOW_SECONDS: begin
            window_setting = value;
         end
         pcfl_pkg::CSR_IGNORE_SECONDS: begin
            ignore_setting = value;
         end
         default: begin
         end
      endcase
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [pcfl_pkg::CFG_W-1:0] threshold,
                                 input logic [pcfl_pkg::CFG_W-1:0] window,
                                 input logic [pcfl_pkg::CFG_W-1:0] ignore_span);
      drain_responses();
      write_register(pcfl_pkg::CSR_FLOOD_THRESHOLD, threshold);
      write_register(pcfl_pkg::CSR_WINDOW_SECONDS, window);
      write_register(pcfl_pkg::CSR_IGNORE_SECONDS, ignore_span);
   endtask

   // With the registers as reset leaves them, limiting is off: every item passes,
   // including those at the ends of the time range.
   task automatic test_disabled_limiting();
      issue_request(pcfl_pkg::MODE_CHECK, '0, '0);
      issue_request(pcfl_pkg::MODE_CHECK, '1, '1);
      issue_request(pcfl_pkg::MODE_SWEEP, '0, '0);
      issue_request(pcfl_pkg::MODE_CHECK, 6'd21, 32'h5555_AAAA);
   endtask

   // A threshold of one ignores a channel on its first message. At time zero the ignore
   // does not stick; at the top of the time range it does, and sweeps with a zero
   // ignore period cannot lift an ignore that has only just begun.
   task automatic test_immediate_ignore();
      apply_settings(16'd1, 16'd0, 16'd0);
      issue_request(pcfl_pkg::MODE_CHECK, '0, '0);
      issue_request(pcfl_pkg::MODE_CHECK, '0, '0);
      issue_request(pcfl_pkg::MODE_CHECK, '1, '1);
      issue_request(pcfl_pkg::MODE_CHECK, '1, '0);
      issue_request(pcfl_pkg::MODE_SWEEP, '1, '1);
      issue_request(pcfl_pkg::MODE_SWEEP, '0, '0);
      issue_request(pcfl_pkg::MODE_CHECK, '1, '1);
   endtask

   // The widest window and the highest threshold first, then a small threshold that
   // floods a channel, a sweep just late enough to lift the longest ignore, and the
   // restart of a window whose start was cleared by the ignore.
   task automatic test_window_and_sweep();
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
      issue_request(pcfl_pkg::MODE_CHECK, 6'd7, 32'd70000);
      issue_request(pcfl_pkg::MODE_CHECK, 6'd7, 32'd4);
      issue_request(pcfl_pkg::MODE_CHECK, 6'd7, 32'd135536);
      drain_responses();
      write_register(pcfl_pkg::CSR_FLOOD_THRESHOLD, 16'd2);
      write_register(pcfl_pkg::CSR_WINDOW_SECONDS, 16'd5);
      issue_request(pcfl_pkg::MODE_CHECK, 6'd9, 32'd1000);
      issue_request(pcfl_pkg::MODE_CHECK, 6'd9, 32'd1003);
      issue_request(pcfl_pkg::MODE_CHECK, 6'd9, 32'd1010);
      issue_request(pcfl_pkg::MODE_SWEEP, 6'd42, 32'd66539);
      issue_request(pcfl_pkg::MODE_CHECK, 6'd9, 32'd66540);
      issue_request(pcfl_pkg::MODE_CHECK, 6'd9, 32'd66541);
      issue_request(pcfl_pkg::MODE_CHECK, 6'd9, 32'd66542);
   endtask

   // Phases of random traffic, each under its own settings. Most items are checks on a
   // few busy channels with time creeping forward, so that windows fill up and ignores
   // begin; sweeps come now and then after a jump in time, and a share of the items is
   // noise with any mode, channel and time.
   task automatic test_random_traffic();
      logic [pcfl_pkg::TIME_W-1:0] now;
      logic [pcfl_pkg::CHAN_W-1:0] busy_chan [4];
      logic [pcfl_pkg::CHAN_W-1:0] ch;
      int                          roll;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               apply_settings(16'hFFFF, 16'hFFFF, 16'd0);
            end
            1: begin
               apply_settings(16'd1, 16'd0, 16'd0);
            end
            7: begin
               apply_settings(pcfl_pkg::CFG_W'($urandom_range(0, 6)),
                              pcfl_pkg::CFG_W'($urandom_range(0, 8)), 16'hFFFF);
            end
            default: begin
               apply_settings(pcfl_pkg::CFG_W'($urandom_range(1, 6)),
                              pcfl_pkg::CFG_W'($urandom_range(0, 8)),
                              pcfl_pkg::CFG_W'($urandom_range(0, 20)));
            end
         endcase
         steady_traffic = (phase == 3);
         // One phase starts just above zero, where the window test compares against a
         // negative bound; another starts just below the top, so that time wraps.
         if (phase == 2) begin
            now = $urandom_range(0, 40);
         end else if (phase == 5) begin
            now = 32'hFFFF_FFFF - $urandom_range(0, 300);
         end else begin
            now = $urandom();
         end
         foreach (busy_chan[i]) begin
            busy_chan[i] = pcfl_pkg::CHAN_W'($urandom_range(0, CHANNELS - 1));
         end
         for (int n = 0; n < 250; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 7) begin
               now = now + $urandom_range(0, 2 * ignore_setting + 4);
               issue_request(pcfl_pkg::MODE_SWEEP,
                             pcfl_pkg::CHAN_W'($urandom_range(0, CHANNELS - 1)), now);
            end else if (roll < 12) begin
               issue_request(1'($urandom_range(0, 1)),
                             pcfl_pkg::CHAN_W'($urandom_range(0, CHANNELS - 1)),
                             $urandom());
            end else begin
               now = now + $urandom_range(0, 2);
               if ($urandom_range(0, 99) < 80) begin
                  ch = busy_chan[2'($urandom_range(0, 3))];
               end else begin
                  ch = pcfl_pkg::CHAN_W'($urandom_range(0, CHANNELS - 1));
               end
               issue_request(pcfl_pkg::MODE_CHECK, ch, now);
            end
         end
         steady_traffic = 1'b0;
      end
   endtask

   // The sink idles at random as well, apart from the steady phase.
   always @(posedge clock) begin
      rsp_chan.ready <= steady_traffic || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Every verdict the block hands over is compared with the oldest one owed.
   always @(posedge clock) begin
      verdict_type owed;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: verdict with none owed, drop %b, ignore_started %b",
                     $time, rsp_chan.drop, rsp_chan.ignore_started);
            mismatch_count++;
         end else begin
            owed = pending_verdicts.pop_front();
            if (rsp_chan.drop !== owed.drop) begin
               $display("%0t: drop mismatch, expected %b, actual %b",
                        $time, owed.drop, rsp_chan.drop);
               mismatch_count++;
            end
            if (rsp_chan.ignore_started !== owed.ignore_started) begin
               $display("%0t: ignore_started mismatch, expected %b, actual %b",
                        $time, owed.ignore_started, rsp_chan.ignore_started);
               mismatch_count++;
            end
         end
      end
   end

   // Ends the run if neither channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
                || (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_chan.valid        = 1'b0;
      req_chan.mode         = pcfl_pkg::MODE_CHECK;
      req_chan.channel      = '0;
      req_chan.current_time = '0;
      csr_wr_en             = 1'b0;
      csr_index             = pcfl_pkg::CSR_FLOOD_THRESHOLD;
      csr_wr_data           = '0;
      threshold_setting     = pcfl_pkg::RST_FLOOD_THRESHOLD;
      window_setting        = pcfl_pkg::RST_WINDOW_SECONDS;
      ignore_setting        = pcfl_pkg::RST_IGNORE_SECONDS;
      for (int c = 0; c < CHANNELS; c++) begin
         chan_known[c]        = 1'b0;
         chan_window_start[c] = '0;
         chan_count[c]        = '0;
         chan_ignored_at[c]   = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_disabled_limiting();
      test_immediate_ignore();
      test_window_and_sweep();
      test_random_traffic();
      drain_responses();

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/pcfl_pkg.sv
src/pcfl_req_if.sv
src/pcfl_rsp_if.sv
src/pcfl_ram.sv
src/pcfl_update.sv
src/per_channel_flood_limiter_unit.sv
bench/per_channel_flood_limiter_unit_test.sv
